@@ rtl/assert_macros.svh @@
// Assertion helpers included by spi_master_majority_sample.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising clk edge outside of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/spims_pkg.sv @@
`default_nettype none

package spims_pkg;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SELECT   = 2'd1,
        CMD_DESELECT = 2'd2,
        CMD_SEND     = 2'd3
    } cmd_t;

    localparam int unsigned BYTE_W        = 8;
    localparam logic [2:0]  LAST_BIT      = 3'd7;
    localparam logic [7:0]  MIN_HALF      = 8'd3;
    localparam logic [7:0]  HALF_RESET    = 8'd5;

    function automatic logic vote3(input logic [2:0] w);
        return (w[0] & w[1]) | (w[0] & w[2]) | (w[1] & w[2]);
    endfunction

endpackage

`default_nettype wire

@@ rtl/spi_master_majority_sample.sv @@
`default_nettype none

// Channel   Handshake               Payload
// -------   ---------------------   ----------------------------------------
// in        in_valid / in_ready     cmd, tx_byte, miso
// out       out_valid / out_ready   csn, sck, mosi, rx_byte, rx_done, busy_res
// cfg       cfg_wr_en               cfg_wr_data (half_period)
//
// Every input beat yields one output beat. A beat is held in the input
// register, then the SPI state and the result register update together, and
// one beat is taken in every cycle while out is not stalled.
// The throughput is set by the single state update per cycle.
// Reset sets the select state to deselected, leaves the master idle and sets half_period to 5.
// A stall on out holds the result register and then the input register.

module spi_master_majority_sample (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_wr_en,
    input  wire [7:0]           cfg_wr_data,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire [1:0]           cmd,
    input  wire [7:0]           tx_byte,
    input  wire                 miso,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic                csn,
    output logic                sck,
    output logic                mosi,
    output logic [7:0]          rx_byte,
    output logic                rx_done,
    output logic                busy_res
);
    import spims_pkg::*;

    `include "assert_macros.svh"

    logic [7:0] half_period_reg;

    // Input register.
    logic       s1_valid_reg;
    cmd_t       s1_cmd_reg;
    logic [7:0] s1_tx_reg;
    logic       s1_miso_reg;

    // SPI state.
    logic [7:0] tx_shift_reg,  tx_shift_next;
    logic [7:0] rx_shift_reg,  rx_shift_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [2:0] window_reg,    window_next;
    logic       high_reg,      high_next;
    logic       active_reg,    active_next;
    logic       select_reg,    select_next;

    // Result register.
    logic       out_valid_reg;
    logic       csn_reg, sck_reg, mosi_reg, done_reg, busy_reg;
    logic [7:0] rx_byte_reg;
    logic       done_next;
    logic [7:0] rx_out_next;

    logic       advance;
    logic       step;
    logic [7:0] hp;
    logic [7:0] last;
    logic       half_end;
    logic [2:0] window_shifted;
    logic       idle_at_rest;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign step     = s1_valid_reg && advance;

    assign hp       = (half_period_reg < MIN_HALF) ? MIN_HALF : half_period_reg;
    assign last     = hp - 8'd1;
    assign half_end = tick_count_reg >= last;
    assign window_shifted = {window_reg[1:0], s1_miso_reg};

    always_comb
    begin
        tx_shift_next   = tx_shift_reg;
        rx_shift_next   = rx_shift_reg;
        bit_index_next  = bit_index_reg;
        tick_count_next = tick_count_reg;
        window_next     = window_reg;
        high_next       = high_reg;
        active_next     = active_reg;
        select_next     = select_reg;
        done_next       = 1'b0;
        rx_out_next     = '0;
        if (!active_reg)
        begin
            case (s1_cmd_reg)
                CMD_SELECT:   select_next = 1'b0;
                CMD_DESELECT: select_next = 1'b1;
                CMD_SEND:
                begin
                    tx_shift_next   = s1_tx_reg;
                    rx_shift_next   = '0;
                    bit_index_next  = '0;
                    tick_count_next = '0;
                    window_next     = '0;
                    high_next       = 1'b0;
                    active_next     = 1'b1;
                end
                default: ;
            endcase
        end
        else if (s1_cmd_reg == CMD_TICK)
        begin
            if (!high_reg)
            begin
                // Samples are taken on the last three ticks of the low half.
                if ({1'b0, tick_count_reg} + 9'd3 >= {1'b0, hp})
                begin
                    window_next = window_shifted;
                end
                if (half_end)
                begin
                    rx_shift_next   = {rx_shift_reg[BYTE_W-2:0], vote3(window_next)};
                    high_next       = 1'b1;
                    tick_count_next = '0;
                end
                else
                begin
                    tick_count_next = tick_count_reg + 8'd1;
                end
            end
            else if (half_end)
            begin
                high_next       = 1'b0;
                tick_count_next = '0;
                window_next     = '0;
                tx_shift_next   = {tx_shift_reg[BYTE_W-2:0], 1'b0};
                if (bit_index_reg == LAST_BIT)
                begin
                    bit_index_next = '0;
                    active_next    = 1'b0;
                    done_next      = 1'b1;
                    rx_out_next    = rx_shift_reg;
                end
                else
                begin
                    bit_index_next = bit_index_reg + 3'd1;
                end
            end
            else
            begin
                tick_count_next = tick_count_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_RESET;
        end
        else if (cfg_wr_en)
        begin
            half_period_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg  <= cmd_t'(cmd);
            s1_tx_reg   <= tx_byte;
            s1_miso_reg <= miso;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg   <= '0;
            rx_shift_reg   <= '0;
            bit_index_reg  <= '0;
            tick_count_reg <= '0;
            window_reg     <= '0;
            high_reg       <= 1'b0;
            active_reg     <= 1'b0;
            select_reg     <= 1'b1;
        end
        else if (step)
        begin
            tx_shift_reg   <= tx_shift_next;
            rx_shift_reg   <= rx_shift_next;
            bit_index_reg  <= bit_index_next;
            tick_count_reg <= tick_count_next;
            window_reg     <= window_next;
            high_reg       <= high_next;
            active_reg     <= active_next;
            select_reg     <= select_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            csn_reg     <= select_next;
            sck_reg     <= high_next;
            mosi_reg    <= tx_shift_next[BYTE_W-1];
            rx_byte_reg <= rx_out_next;
            done_reg    <= done_next;
            busy_reg    <= active_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign csn       = csn_reg;
    assign sck       = sck_reg;
    assign mosi      = mosi_reg;
    assign rx_byte   = rx_byte_reg;
    assign rx_done   = done_reg;
    assign busy_res  = busy_reg;

    assign idle_at_rest = (tick_count_reg == 8'd0) && !high_reg && (bit_index_reg == 3'd0);

    // A completed byte always ends the transfer.
    `ASSERT_NEVER(a_done_while_busy, out_valid_reg && done_reg && busy_reg, "rx_done while busy")
    // Idle master keeps its bit timing at rest.
    `ASSERT_CLK(a_idle_timing, !active_reg |-> idle_at_rest, "idle timing not at rest")
    // A stalled result stays in the output register.
    `ASSERT_CLK(a_out_hold, out_valid_reg && !out_ready |=> out_valid_reg, "output beat dropped")
    // A beat in the input stage is never lost while the output is stalled.
    `ASSERT_CLK(a_in_hold, s1_valid_reg && !advance |=> s1_valid_reg, "input beat dropped")

endmodule

`default_nettype wire
